@@ rtl/mpca_pkg.sv @@
// ----------------------------------------------------------------------------
// mpca_pkg
// Shared types and constants of the masked pixel complex ALU.
// ----------------------------------------------------------------------------
package mpca_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int EPS_W          = 17;
	localparam int PADDR_W        = 5;
	localparam int PDATA_W        = 32;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [2:0] {
		REG_OPERATION,
		REG_FIRST_CPLX,
		REG_SECOND_CPLX,
		REG_OUTPUT_CPLX,
		REG_EPSILON
	} reg_idx_t;

endpackage

@@ rtl/mpca_in_if.sv @@
// ----------------------------------------------------------------------------
// mpca_in_if
// Pixel pair channel: two Q operands and a mask bit, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpca_in_if #(
	parameter int DATA_WIDTH = mpca_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] first_real;
	logic signed [DATA_WIDTH-1:0] first_imag;
	logic signed [DATA_WIDTH-1:0] second_real;
	logic signed [DATA_WIDTH-1:0] second_imag;
	logic                         pixel_valid;

	modport source (
		output valid, first_real, first_imag, second_real, second_imag, pixel_valid,
		input  ready
	);
	modport sink (
		input  valid, first_real, first_imag, second_real, second_imag, pixel_valid,
		output ready
	);
endinterface

@@ rtl/mpca_out_if.sv @@
// ----------------------------------------------------------------------------
// mpca_out_if
// Result channel: saturated Q result and status flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpca_out_if #(
	parameter int DATA_WIDTH = mpca_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] result_real;
	logic signed [DATA_WIDTH-1:0] result_imag;
	logic                         divide_fault;
	logic                         saturated;

	modport source (
		output valid, result_real, result_imag, divide_fault, saturated,
		input  ready
	);
	modport sink (
		input  valid, result_real, result_imag, divide_fault, saturated,
		output ready
	);
endinterface

@@ rtl/masked_pixel_complex_alu.sv @@
// ----------------------------------------------------------------------------
// masked_pixel_complex_alu
// Per-pixel add, subtract, multiply and divide of real or complex Q operands.
// ----------------------------------------------------------------------------
// Every operation passes through the same stages; the restoring divider, one
// quotient bit per stage, sets the depth.
// Throughput: one beat per cycle unless the output stalls; each stage holds
// only while the one after it is full and stalled, so bubbles close up.
// Reset: clears all stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module masked_pixel_complex_alu #(
	parameter int DATA_WIDTH = mpca_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mpca_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mpca_pkg::PADDR_W-1:0]    paddr,
	input  logic [mpca_pkg::PDATA_W-1:0]    pwdata,
	output logic [mpca_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	mpca_in_if.sink                         in_ch,
	mpca_out_if.source                      out_ch
);
	import mpca_pkg::*;

	localparam int DW  = DATA_WIDTH;
	localparam int FB  = FRAC_BITS;
	localparam int SW  = DW + 1;
	localparam int DNW = DW + 2;
	localparam int PW  = 2 * DW;
	localparam int NW  = 2 * DW + 1;
	localparam int WX  = 3 * DW + 1;
	localparam int ND  = DW;
	localparam int NS  = ND + 5;
	localparam int EW_PAD = EPS_W;
	localparam logic [WX-1:0] MAXP = {{(WX-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [WX-1:0] MINM = MAXP + 1'b1;

	// ---------------- configuration registers ----------------
	op_t              op_q;
	logic             fic_q, sic_q, oc_q;
	logic [EPS_W-1:0] eps_q;
	reg_idx_t         ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q  <= OP_ADD;
			fic_q <= 1'b1;
			sic_q <= 1'b1;
			oc_q  <= 1'b1;
			eps_q <= EPS_W'(1);
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_OPERATION:   op_q  <= op_t'(pwdata[1:0]);
				REG_FIRST_CPLX:  fic_q <= pwdata[0];
				REG_SECOND_CPLX: sic_q <= pwdata[0];
				REG_OUTPUT_CPLX: oc_q  <= pwdata[0];
				REG_EPSILON:     eps_q <= pwdata[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (ridx)
			REG_OPERATION:   prdata[1:0]       = op_q;
			REG_FIRST_CPLX:  prdata[0]         = fic_q;
			REG_SECOND_CPLX: prdata[0]         = sic_q;
			REG_OUTPUT_CPLX: prdata[0]         = oc_q;
			REG_EPSILON:     prdata[EPS_W-1:0] = eps_q;
			default: ;
		endcase
	end

	// ---------------- stage valids and enables ----------------
	logic [NS-1:0] vld_s;
	logic [NS-1:0] en;

	assign en[NS-1] = ~vld_s[NS-1] | out_ch.ready;
	for (genvar k = 0; k < NS - 1; k++) begin : g_en
		assign en[k] = ~vld_s[k] | en[k+1];
	end
	assign in_ch.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) vld_s[0] <= in_ch.valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// ---------------- stage 1: operand select, real divisor ----------------
	logic signed [DW-1:0]  a_s1, b_s1, c_s1, d_s1;
	logic signed [DNW-1:0] den_s1;
	logic                  pv_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1   <= in_ch.first_real;
			b_s1   <= fic_q ? in_ch.first_imag : '0;
			c_s1   <= in_ch.second_real;
			d_s1   <= sic_q ? in_ch.second_imag : '0;
			den_s1 <= DNW'(in_ch.second_real) + $signed({{(DNW-EW_PAD){1'b0}}, eps_q});
			pv_s1  <= in_ch.pixel_valid;
		end
	end

	// ---------------- stage 2: products and sums ----------------
	logic signed [PW-1:0]  ac_s2, bd_s2, ad_s2, bc_s2, cc_s2, dd_s2;
	logic signed [SW-1:0]  rsum_s2, isum_s2;
	logic signed [DW-1:0]  a_s2, b_s2;
	logic signed [DNW-1:0] den_s2;
	logic                  pv_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ac_s2   <= a_s1 * c_s1;
			bd_s2   <= b_s1 * d_s1;
			ad_s2   <= a_s1 * d_s1;
			bc_s2   <= b_s1 * c_s1;
			cc_s2   <= c_s1 * c_s1;
			dd_s2   <= d_s1 * d_s1;
			rsum_s2 <= (op_q == OP_SUB) ? SW'(a_s1) - SW'(c_s1) : SW'(a_s1) + SW'(c_s1);
			isum_s2 <= (op_q == OP_SUB) ? SW'(b_s1) - SW'(d_s1) : SW'(b_s1) + SW'(d_s1);
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			den_s2  <= den_s1;
			pv_s2   <= pv_s1;
		end
	end

	// ---------------- stage 3: numerators and divisor ----------------
	logic signed [NW-1:0]  num_c [2];
	logic [PW-1:0]         dmag_c;
	logic                  dn_c;
	logic signed [DNW-1:0] aden;
	logic signed [NW-1:0]  num_s3 [2];
	logic [PW-1:0]         dmag_s3;
	logic                  dn_s3, pv_s3;

	always_comb begin
		aden     = den_s2[DNW-1] ? -den_s2 : den_s2;
		num_c[0] = NW'(rsum_s2);
		num_c[1] = NW'(isum_s2);
		dmag_c   = '0;
		dn_c     = 1'b0;
		case (op_q)
			OP_MUL: begin
				num_c[0] = NW'(ac_s2) - NW'(bd_s2);
				num_c[1] = NW'(ad_s2) + NW'(bc_s2);
			end
			OP_DIV: begin
				if (sic_q) begin
					num_c[0] = NW'(ac_s2) + NW'(bd_s2);
					num_c[1] = NW'(bc_s2) - NW'(ad_s2);
					dmag_c   = $unsigned(cc_s2) + $unsigned(dd_s2);
				end else begin
					num_c[0] = NW'(a_s2);
					num_c[1] = NW'(b_s2);
					dmag_c   = PW'($unsigned(aden));
					dn_c     = den_s2[DNW-1];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			num_s3  <= num_c;
			dmag_s3 <= dmag_c;
			dn_s3   <= dn_c;
			pv_s3   <= pv_s2;
		end
	end

	// ---------------- stage 4 and divider pipe ----------------
	// element 0 is stage 4; element j carries quotient bits down to ND - j
	logic [WX-1:0] dv_rem_s   [0:ND][2];
	logic [DW-1:0] dv_q_s     [0:ND][2];
	logic          dv_neg_s   [0:ND][2];
	logic          dv_big_s   [0:ND][2];
	logic [PW-1:0] dv_dmag_s  [0:ND];
	logic          dv_isdiv_s [0:ND];
	logic          dv_fault_s [0:ND];
	logic          dv_pv_s    [0:ND];

	logic [WX-1:0] rem_c [2];
	logic          neg_c [2];
	logic          big_c [2];
	logic          isdiv_c, fault_c;

	always_comb begin
		logic signed [NW-1:0] sv;
		logic [NW-1:0]        m;
		isdiv_c = (op_q == OP_DIV);
		fault_c = isdiv_c && (dmag_s3 == '0);
		for (int p = 0; p < 2; p++) begin
			sv       = (op_q == OP_MUL) ? (num_s3[p] >>> FB) : num_s3[p];
			m        = sv[NW-1] ? $unsigned(-sv) : $unsigned(sv);
			neg_c[p] = sv[NW-1] ^ (isdiv_c & dn_s3);
			if (!isdiv_c) begin
				big_c[p] = 1'b0;
				rem_c[p] = WX'(m);
			end else begin
				rem_c[p] = WX'(m) << FB;
				if (fault_c) big_c[p] = (m != '0);
				else         big_c[p] = (rem_c[p] >= (WX'(dmag_s3) << DW));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			dv_rem_s[0]   <= rem_c;
			dv_q_s[0][0]  <= '0;
			dv_q_s[0][1]  <= '0;
			dv_neg_s[0]   <= neg_c;
			dv_big_s[0]   <= big_c;
			dv_dmag_s[0]  <= dmag_s3;
			dv_isdiv_s[0] <= isdiv_c;
			dv_fault_s[0] <= fault_c;
			dv_pv_s[0]    <= pv_s3;
		end
	end

	for (genvar j = 1; j <= ND; j++) begin : g_div
		localparam int BI = ND - j;
		logic [WX-1:0] sub;
		logic [WX-1:0] rem_n [2];
		logic [DW-1:0] q_n   [2];

		always_comb begin
			logic take;
			sub = WX'(dv_dmag_s[j-1]) << BI;
			for (int p = 0; p < 2; p++) begin
				take = dv_isdiv_s[j-1] && !dv_fault_s[j-1] && !dv_big_s[j-1][p]
					&& (dv_rem_s[j-1][p] >= sub);
				rem_n[p]     = take ? dv_rem_s[j-1][p] - sub : dv_rem_s[j-1][p];
				q_n[p]       = dv_q_s[j-1][p];
				q_n[p][BI]   = take;
			end
		end

		always_ff @(posedge clk) begin
			if (en[3+j]) begin
				dv_rem_s[j]   <= rem_n;
				dv_q_s[j]     <= q_n;
				dv_neg_s[j]   <= dv_neg_s[j-1];
				dv_big_s[j]   <= dv_big_s[j-1];
				dv_dmag_s[j]  <= dv_dmag_s[j-1];
				dv_isdiv_s[j] <= dv_isdiv_s[j-1];
				dv_fault_s[j] <= dv_fault_s[j-1];
				dv_pv_s[j]    <= dv_pv_s[j-1];
			end
		end
	end

	// ---------------- output stage: saturate, mask ----------------
	logic signed [DW-1:0] val_c [2];
	logic                 clip_c [2];
	logic signed [DW-1:0] res_re_s, res_im_s;
	logic                 fault_s, sat_s;

	always_comb begin
		logic [WX-1:0] m;
		for (int p = 0; p < 2; p++) begin
			m = dv_isdiv_s[ND] ? WX'(dv_q_s[ND][p]) : dv_rem_s[ND][p];
			if (!dv_neg_s[ND][p]) begin
				clip_c[p] = dv_big_s[ND][p] || (m > MAXP);
				val_c[p]  = clip_c[p] ? DW'(MAXP) : DW'(m);
			end else begin
				clip_c[p] = dv_big_s[ND][p] || (m > MINM);
				val_c[p]  = clip_c[p] ? DW'(MINM) : -DW'(m);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			res_re_s <= dv_pv_s[ND] ? val_c[0] : '0;
			res_im_s <= (dv_pv_s[ND] && oc_q) ? val_c[1] : '0;
			fault_s  <= dv_pv_s[ND] && dv_fault_s[ND];
			sat_s    <= dv_pv_s[ND] && (clip_c[0] || (oc_q && clip_c[1]));
		end
	end

	assign out_ch.valid        = vld_s[NS-1];
	assign out_ch.result_real  = res_re_s;
	assign out_ch.result_imag  = res_im_s;
	assign out_ch.divide_fault = fault_s;
	assign out_ch.saturated    = sat_s;

endmodule

@@ tb/mpca_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// mpca_tb_pkg
// Pixel and result records used by the ALU testbench.
// ----------------------------------------------------------------------------
package mpca_tb_pkg;

	typedef struct packed {
		logic signed [31:0] first_real;
		logic signed [31:0] first_imag;
		logic signed [31:0] second_real;
		logic signed [31:0] second_imag;
		logic               pixel_valid;
	} pixel_t;

	typedef struct packed {
		logic signed [31:0] result_real;
		logic signed [31:0] result_imag;
		logic               divide_fault;
		logic               saturated;
	} alu_result_t;

endpackage

@@ tb/tb_masked_pixel_complex_alu.sv @@
// ----------------------------------------------------------------------------
// tb_masked_pixel_complex_alu
// Self-checking bench for the masked pixel complex ALU: a queued pixel driver
// and a result monitor under random idling, checked against an in-bench
// arithmetic predictor across every operation and operand format.
// ----------------------------------------------------------------------------
module tb_masked_pixel_complex_alu;
	timeunit 1ns;
	timeprecision 1ps;

	import mpca_pkg::*;
	import mpca_tb_pkg::*;

	localparam int LATENCY = 37;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [63:0] MAXP = 64'h7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	mpca_in_if  in_ch ();
	mpca_out_if out_ch ();

	masked_pixel_complex_alu dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #6 clk = ~clk;

	// configuration copy
	op_t         cur_op = OP_ADD;
	logic        cur_fc = 1'b1, cur_sc = 1'b1, cur_oc = 1'b1;
	logic [16:0] cur_eps = 17'd1;

	pixel_t      pending_pixels[$];
	alu_result_t expected_results[$];
	int          error_count = 0, pixel_count = 0, result_count = 0;
	int          sender_idle_pct = 19, receiver_idle_pct = 19;
	longint      cycle_count = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// magnitude and sign accumulation: pos - neg gives the signed sum
	function automatic void resolve_sum(input logic [63:0] pos, input logic [63:0] neg,
			output logic [63:0] m, output bit n);
		if (pos >= neg) begin
			m = pos - neg; n = 0;
		end else begin
			m = neg - pos; n = 1;
		end
	endfunction

	function automatic logic [63:0] mag64(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic void add_prod(inout logic [63:0] pos, inout logic [63:0] neg,
			input longint x, input longint y, input bit minus);
		logic [63:0] m;
		m = mag64(x) * mag64(y);
		if (((x < 0) != (y < 0)) != minus) neg += m;
		else pos += m;
	endfunction

	function automatic void add_val(inout logic [63:0] pos, inout logic [63:0] neg,
			input longint v, input bit minus);
		if ((v < 0) != minus) neg += mag64(v);
		else pos += mag64(v);
	endfunction

	function automatic logic [63:0] fixed_quotient(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q, r;
		bit over, b;
		q = n / d; r = n % d; over = 0;
		for (int i = 0; i < 16; i++) begin
			if (q > (64'd1 << 62)) over = 1;
			r = r << 1;
			b = 0;
			if (r >= d) begin
				r -= d; b = 1;
			end
			if (!over) q = (q << 1) | 64'(b);
		end
		return over ? '1 : q;
	endfunction

	function automatic logic [31:0] clip_q(input bit n, input logic [63:0] m, inout bit clip);
		if (!n) begin
			if (m > MAXP) begin
				clip = 1; return 32'h7FFF_FFFF;
			end
			return m[31:0];
		end
		if (m > MAXP + 1) begin
			clip = 1; m = MAXP + 1;
		end
		return 32'(-m);
	endfunction

	function automatic alu_result_t predict_pixel(input pixel_t p);
		alu_result_t r;
		longint a, b, c, d, den;
		logic [63:0] rp, rn_, ip, in_, rm, im, dm;
		bit rneg, ineg, dneg, rclip, iclip;
		r = '0;
		if (!p.pixel_valid) return r;
		a = p.first_real; b = cur_fc ? longint'(p.first_imag) : 0;
		c = p.second_real; d = cur_sc ? longint'(p.second_imag) : 0;
		rp = 0; rn_ = 0; ip = 0; in_ = 0; rclip = 0; iclip = 0;
		case (cur_op)
			OP_ADD, OP_SUB: begin
				add_val(rp, rn_, a, 0); add_val(rp, rn_, c, cur_op == OP_SUB);
				add_val(ip, in_, b, 0); add_val(ip, in_, d, cur_op == OP_SUB);
				resolve_sum(rp, rn_, rm, rneg); resolve_sum(ip, in_, im, ineg);
			end
			OP_MUL: begin
				add_prod(rp, rn_, a, c, 0); add_prod(rp, rn_, b, d, 1);
				add_prod(ip, in_, a, d, 0); add_prod(ip, in_, b, c, 0);
				resolve_sum(rp, rn_, rm, rneg); resolve_sum(ip, in_, im, ineg);
				// floor toward minus infinity
				rm = rneg ? (rm + 64'hFFFF) >> 16 : rm >> 16;
				im = ineg ? (im + 64'hFFFF) >> 16 : im >> 16;
			end
			default: begin
				if (cur_sc) begin
					dm = mag64(c) * mag64(c) + mag64(d) * mag64(d); dneg = 0;
					add_prod(rp, rn_, a, c, 0); add_prod(rp, rn_, b, d, 0);
					add_prod(ip, in_, b, c, 0); add_prod(ip, in_, a, d, 1);
				end else begin
					den = c + longint'(cur_eps);
					dm = mag64(den); dneg = den < 0;
					add_val(rp, rn_, a, 0); add_val(ip, in_, b, 0);
				end
				resolve_sum(rp, rn_, rm, rneg); resolve_sum(ip, in_, im, ineg);
				if (dm == 0) begin
					r.divide_fault = 1;
					if (rm != 0) rm = '1;
					if (im != 0) im = '1;
				end else begin
					rm = fixed_quotient(rm, dm); im = fixed_quotient(im, dm);
					rneg = rneg != dneg; ineg = ineg != dneg;
				end
			end
		endcase
		r.result_real = clip_q(rneg, rm, rclip);
		r.result_imag = clip_q(ineg, im, iclip);
		if (!cur_oc) begin
			r.result_imag = 0; iclip = 0;
		end
		r.saturated = rclip | iclip;
		return r;
	endfunction

	// driver: present the next queued pixel, predict it on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_results.push_back(predict_pixel({in_ch.first_real, in_ch.first_imag,
					in_ch.second_real, in_ch.second_imag, in_ch.pixel_valid}));
				pixel_count++;
			end
			if ((!in_ch.valid || in_ch.ready) ) begin
				if (pending_pixels.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					pixel_t p;
					p = pending_pixels.pop_front();
					in_ch.valid       <= 1'b1;
					in_ch.first_real  <= p.first_real;
					in_ch.first_imag  <= p.first_imag;
					in_ch.second_real <= p.second_real;
					in_ch.second_imag <= p.second_imag;
					in_ch.pixel_valid <= p.pixel_valid;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	initial begin
		in_ch.first_real = '0; in_ch.first_imag = '0; in_ch.second_real = '0;
		in_ch.second_imag = '0; in_ch.pixel_valid = 1'b0; out_ch.ready = 1'b0;
	end

	// monitor: compare each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (out_ch.valid && out_ch.ready) begin
				result_count++;
				if (expected_results.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					alu_result_t e;
					e = expected_results.pop_front();
					if (out_ch.result_real !== e.result_real)
						report_mismatch($sformatf("result_real %h, want %h",
							out_ch.result_real, e.result_real));
					if (out_ch.result_imag !== e.result_imag)
						report_mismatch($sformatf("result_imag %h, want %h",
							out_ch.result_imag, e.result_imag));
					if (out_ch.divide_fault !== e.divide_fault)
						report_mismatch($sformatf("divide_fault %b, want %b",
							out_ch.divide_fault, e.divide_fault));
					if (out_ch.saturated !== e.saturated)
						report_mismatch($sformatf("saturated %b, want %b",
							out_ch.saturated, e.saturated));
				end
			end
			out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("timeout with %0d results outstanding", expected_results.size());
				$display("tb_masked_pixel_complex_alu: errors");
				$finish;
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= PADDR_W'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_OPERATION:   cur_op = op_t'(val[1:0]);
			REG_FIRST_CPLX:  cur_fc = val[0];
			REG_SECOND_CPLX: cur_sc = val[0];
			REG_OUTPUT_CPLX: cur_oc = val[0];
			default:         cur_eps = val[16:0];
		endcase
	endtask

	task automatic drain;
		while (pending_pixels.size() > 0 || in_ch.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(5))
			0: return 32'h8000_0000 | ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h0);
			1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			2: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.first_real = rand_operand(); p.first_imag = rand_operand();
		p.second_real = rand_operand(); p.second_imag = rand_operand();
		p.pixel_valid = ($urandom_range(9) != 0);
		return p;
	endfunction

	task automatic queue_pixel(input logic [31:0] ar, ai, br, bi, input logic m);
		pending_pixels.push_back({ar, ai, br, bi, m});
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: extremes, masking and zero divisors over each operation and format
		queue_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
		queue_pixel(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1);
		queue_pixel(32'hFFFF_FFFF, 32'h1234_5678, 32'h0001_0000, 32'h0, 0);
		drain();
		write_reg(REG_OPERATION, OP_SUB);
		queue_pixel(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1);
		queue_pixel(32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0, 1);
		drain();
		write_reg(REG_OPERATION, OP_MUL);
		queue_pixel(32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0, 1);
		queue_pixel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
		queue_pixel(32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0001_8000, 1);
		drain();
		write_reg(REG_OPERATION, OP_DIV);
		queue_pixel(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 1);
		queue_pixel(32'h0, 32'h0, 32'h0, 32'h0, 1);
		queue_pixel(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0, 1);
		queue_pixel(32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 1);
		drain();
		write_reg(REG_SECOND_CPLX, 0);
		write_reg(REG_EPSILON, 32'h1_0000);
		queue_pixel(32'h0005_0000, 32'hFFFE_0000, 32'hFFFF_0000, 32'h1111_1111, 1);
		queue_pixel(32'h0005_0000, 32'h0, 32'hFFFF_0000, 32'h0, 1);
		queue_pixel(32'h0, 32'h8000_0000, 32'hFFFF_0000, 32'h0, 1);
		drain();
		write_reg(REG_EPSILON, 32'h0);
		write_reg(REG_FIRST_CPLX, 0);
		write_reg(REG_OUTPUT_CPLX, 0);
		queue_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0, 1);
		queue_pixel(32'h8000_0000, 32'h1, 32'h0, 32'h0, 1);
		queue_pixel(32'h0001_0000, 32'h0, 32'h8000_0000, 32'h0, 1);
		drain();

		// random phases over many settings; the first has no idling at all
		for (int ph = 0; ph < 16; ph++) begin
			sender_idle_pct = (ph == 0) ? 0 : 19;
			receiver_idle_pct = (ph == 0) ? 0 : 19;
			write_reg(REG_OPERATION, (ph < 4) ? ph : $urandom_range(3));
			write_reg(REG_FIRST_CPLX, $urandom_range(1));
			write_reg(REG_SECOND_CPLX, $urandom_range(1));
			write_reg(REG_OUTPUT_CPLX, $urandom_range(1));
			case ($urandom_range(3))
				0: write_reg(REG_EPSILON, 32'h0);
				1: write_reg(REG_EPSILON, 32'h1_0000);
				default: write_reg(REG_EPSILON, $urandom_range(17'h1FFFF));
			endcase
			for (int k = 0; k < 25; k++) begin
				pixel_t p;
				p = rand_pixel();
				// aim some real divisors at exactly minus epsilon
				if (cur_op == OP_DIV && !cur_sc && $urandom_range(4) == 0)
					p.second_real = -32'(cur_eps);
				pending_pixels.push_back(p);
				// hold the sender once until everything has come back
				if (ph == 5 && k == 12) begin
					while (pending_pixels.size() > 0 || in_ch.valid
							|| expected_results.size() > 0)
						@(posedge clk);
				end
			end
			drain();
		end

		$display("covered %0d pixels and %0d results over all four operations,", pixel_count,
			result_count);
		$display("real and complex operand and output formats, masking and zero divisors");
		if (error_count == 0) begin
			$display("tb_masked_pixel_complex_alu: clean");
		end else begin
			$display("tb_masked_pixel_complex_alu: errors");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/mpca_pkg.sv
rtl/mpca_in_if.sv
rtl/mpca_out_if.sv
rtl/masked_pixel_complex_alu.sv
tb/mpca_tb_pkg.sv
tb/tb_masked_pixel_complex_alu.sv
